@@ hdl/energy_histogram_binner_unit_defines.svh @@
// Assertion macros shared by the checker of the energy histogram binner.
// Depends on nothing; the checker file includes it by its bare name.
`ifndef ENERGY_HISTOGRAM_BINNER_UNIT_DEFINES_SVH
`define ENERGY_HISTOGRAM_BINNER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EHB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("histogram binner check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("histogram binner check failed");

`endif

@@ hdl/ehb_pkg.sv @@
// Package of the energy histogram binner: field widths, codes, request and
// response types. Depends on nothing.
package ehb_pkg;

  localparam int unsigned ENERGY_W        = 24;
  localparam int unsigned DIVIDEND_W      = 23;
  localparam int unsigned SEL_W           = 12;
  localparam int unsigned BW_W            = 16;
  localparam int unsigned BIU_W           = 13;
  localparam int unsigned REPORT_W        = 32;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned DIV_CNT_W       = $clog2(DIVIDEND_W);

  localparam logic [BW_W-1:0]  BIN_WIDTH_RST   = 16'd16;
  localparam logic [BIU_W-1:0] BINS_IN_USE_RST = 13'd4096;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_WIDTH   = 1'b0,
    CFG_BINS_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [ENERGY_W-1:0] energy;
    logic [SEL_W-1:0]           bin_select;
  } req_t;

  typedef struct packed {
    logic                counted;
    logic [SEL_W-1:0]    bin_index;
    logic [REPORT_W-1:0] bin_count;
  } rsp_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [BW_W-1:0]       remainder;
  } div_rsp_t;

endpackage

@@ hdl/ehb_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ehb_pkg.
module ehb_divider
  import ehb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [BW_W-1:0]       divisor_i,
  output div_rsp_t              result_o
);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [BW_W-1:0]       rem_q, rem_d;
  logic [BW_W-1:0]       div_q, div_d;
  logic [BW_W:0]         rem_sh;
  logic [BW_W:0]         trial;
  logic                  fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
    trial  = rem_sh - {1'b0, div_q};
    fits   = rem_sh >= {1'b0, div_q};
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (run_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      rem_d = fits ? trial[BW_W-1:0] : rem_sh[BW_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign result_o = '{done: done_q, quotient: quo_q, remainder: rem_q};

endmodule

@@ hdl/ehb_bin_mem.sv @@
// Single-port-write, single-port-read count memory with registered read data.
// Depends on nothing.
module ehb_bin_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/energy_histogram_binner_unit.sv @@
// Energy histogram binner of a multichannel analyzer, top level.
// Depends on ehb_pkg, ehb_divider and ehb_bin_mem.
//
// Usage: a request is taken at a rising edge where start_i is high and busy_o
// is low. An add request bins a signed energy by floor(energy / bin_width);
// the event is counted when the energy is positive, the bin_width nonzero,
// the energy not exactly on a bin edge and the bin below bins_in_use - 1 and
// inside storage. A read request returns one bin's count, a clear request
// zeroes every bin. Each request gives one result on rsp_o, marked by done_o
// for exactly one cycle; the receiver cannot stall it. An add that passes the
// sign and width checks goes through the 23-step bit-serial divider and, if
// the bin is counted, a memory read and a write-back. A read of a stored bin
// passes through the read and update states. Rejected adds, reads beyond
// storage and the unused op code answer in the next cycle and leave the block
// ready. A clear walks the memory one bin per cycle. After reset the same
// clearing pass runs with busy_o high and no result. The configuration port
// writes bin_width and bins_in_use at any edge; change them only while idle.
// One request is in flight at a time, and the next may be accepted in the
// cycle its predecessor's result is shown.
module energy_histogram_binner_unit
  import ehb_pkg::*;
#(
  parameter int unsigned NUM_BINS   = 4096,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  req_t                 req_i,
  output logic                 done_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BW_W-1:0]      cfg_wdata_i
);

  localparam int unsigned ADDR_W = $clog2(NUM_BINS);
  localparam int unsigned CMP_W  = 32;
  localparam int unsigned REP_W  = (COUNT_BITS > REPORT_W) ? COUNT_BITS : REPORT_W;

  // Clip a stored count to the reported 32-bit range.
  function automatic logic [REPORT_W-1:0] report(input logic [COUNT_BITS-1:0] cnt);
    logic [REP_W-1:0] wide;
    wide = REP_W'(cnt);
    if (wide > REP_W'({REPORT_W{1'b1}})) begin
      return '1;
    end
    return wide[REPORT_W-1:0];
  endfunction

  state_e state_q, state_d;

  logic [BW_W-1:0]   bin_width_q;
  logic [BIU_W-1:0]  bins_q;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [SEL_W-1:0]  idx_q, idx_d;
  logic              is_add_q, is_add_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_rsp_q, clr_rsp_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  logic              accept;
  logic              pre_ok;
  logic              sel_in_store;
  logic [CMP_W-1:0]  sel_wide;
  logic [CMP_W-1:0]  q_wide;
  logic              hit;
  logic              clr_last;

  logic              div_start;
  div_rsp_t          div_rsp;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] mem_rdata;
  logic [COUNT_BITS-1:0] cnt_inc;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= BIN_WIDTH_RST;
      bins_q      <= BINS_IN_USE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_BIN_WIDTH:   bin_width_q <= cfg_wdata_i;
        CFG_BINS_IN_USE: bins_q      <= cfg_wdata_i[BIU_W-1:0];
        default:         bins_q      <= bins_q;
      endcase
    end
  end

  assign accept = start_i && (state_q == ST_IDLE);

  // An add can only be counted for a positive energy and a nonzero width.
  assign pre_ok = !req_i.energy[ENERGY_W-1] && (req_i.energy != '0) &&
                  (bin_width_q != '0);

  assign sel_wide     = CMP_W'(req_i.bin_select);
  assign sel_in_store = sel_wide < CMP_W'(NUM_BINS);

  // Once the quotient is ready, the event counts when the remainder is nonzero
  // and the bin is both in use and inside storage.
  assign q_wide = CMP_W'(div_rsp.quotient);
  assign hit = (div_rsp.remainder != '0) &&
               (({1'b0, div_rsp.quotient} + (DIVIDEND_W+1)'(1)) <
                (DIVIDEND_W+1)'(bins_q)) &&
               (q_wide < CMP_W'(NUM_BINS));

  assign clr_last = clr_cnt_q == ADDR_W'(NUM_BINS - 1);

  assign cnt_inc = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_BITS'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(req_i.op))
            OP_ADD:   state_d = pre_ok ? ST_DIV : ST_IDLE;
            OP_READ:  state_d = sel_in_store ? ST_READ : ST_IDLE;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = hit ? ST_READ : ST_IDLE;
        end
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Datapath controls and result.
  always_comb begin
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    addr_d    = addr_q;
    idx_d     = idx_q;
    is_add_d  = is_add_q;
    clr_cnt_d = clr_cnt_q;
    clr_rsp_d = clr_rsp_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_last) begin
          done_d    = clr_rsp_q;
          rsp_d     = '0;
          clr_rsp_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(req_i.op))
            OP_ADD: begin
              is_add_d  = 1'b1;
              div_start = pre_ok;
              if (!pre_ok) begin
                done_d = 1'b1;
                rsp_d  = '0;
              end
            end
            OP_READ: begin
              is_add_d = 1'b0;
              addr_d   = sel_wide[ADDR_W-1:0];
              idx_d    = req_i.bin_select;
              if (!sel_in_store) begin
                // A bin beyond storage reads as an empty bin.
                done_d = 1'b1;
                rsp_d  = '{counted: 1'b0, bin_index: req_i.bin_select, bin_count: '0};
              end
            end
            OP_CLEAR: begin
              clr_cnt_d = '0;
              clr_rsp_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = '0;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          addr_d = q_wide[ADDR_W-1:0];
          idx_d  = div_rsp.quotient[SEL_W-1:0];
          if (!hit) begin
            done_d = 1'b1;
            rsp_d  = '0;
          end
        end
      end
      ST_READ: begin
        // The memory read of addr_q is in flight.
      end
      ST_UPDATE: begin
        done_d = 1'b1;
        if (is_add_q) begin
          mem_we    = 1'b1;
          mem_wdata = cnt_inc;
          rsp_d     = '{counted: 1'b1, bin_index: idx_q, bin_count: report(cnt_inc)};
        end else begin
          rsp_d     = '{counted: 1'b0, bin_index: idx_q, bin_count: report(mem_rdata)};
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      clr_rsp_q <= 1'b0;
      done_q    <= 1'b0;
      is_add_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      clr_rsp_q <= clr_rsp_d;
      done_q    <= done_d;
      is_add_q  <= is_add_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    idx_q  <= idx_d;
    rsp_q  <= rsp_d;
  end

  ehb_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.energy[DIVIDEND_W-1:0]),
    .divisor_i  (bin_width_q),
    .result_o   (div_rsp)
  );

  ehb_bin_mem #(
    .DEPTH  (NUM_BINS),
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_BITS)
  ) u_bin_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  assign busy_o = state_q != ST_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ hdl/ehb_checker.sv @@
// Port-level checker of the energy histogram binner and its bind statement.
// Depends on ehb_pkg and energy_histogram_binner_unit_defines.svh.
`include "energy_histogram_binner_unit_defines.svh"

module ehb_checker
  import ehb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input req_t req_i,
  input logic done_o,
  input rsp_t rsp_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  // A counted event has always raised its bin above zero.
  `EHB_ASSERT_NOW(a_counted_nonzero, clk_i, rst_ni, done_o && rsp_o.counted, rsp_o.bin_count != '0)

  // An accepted request either answers at once or keeps the block busy.
  `EHB_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, accept, busy_o || done_o)

  // A counted event went through the divider and memory, so the block was busy.
  `EHB_ASSERT_NOW(a_counted_after_busy, clk_i, rst_ni, done_o && rsp_o.counted, $past(busy_o))

  // No result appears without a request having been taken or being worked on.
  `EHB_ASSERT_NOW(a_no_spurious_done, clk_i, rst_ni, done_o, $past(accept) || $past(busy_o))

endmodule

bind energy_histogram_binner_unit ehb_checker u_ehb_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);
